[sv/slpq_pkg.sv]
`default_nettype none

package slpq_pkg;

  // default node store size
  localparam int CAPACITY_DEF = 16;

  // fixed field widths
  localparam int ELEM_W    = 16;
  localparam int PRIO_W    = 16;
  localparam int COUNT_W   = 5;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int MODE_W    = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_TOP    = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // order test stored-vs-new applied while walking
  typedef enum logic [MODE_W-1:0] {
    REL_LE = 2'd0,
    REL_LT = 2'd1,
    REL_GE = 2'd2,
    REL_GT = 2'd3
  } rel_t;

  // compare unit results
  typedef struct packed {
    logic keep;
    logic match;
  } cmp_res_t;

endpackage

`default_nettype wire

[sv/sorted_list_priority_queue.sv]
// operation: a push walks k nodes from the head (k = 0..CAPACITY-1) and links in the new node,
//   a lookup walks k = 1..CAPACITY nodes, pop and top read the head only, and a full push or an
//   empty pop, top or lookup goes straight to the result; the list walk reads one node per cycle
//   through the node and link memories; no new request is taken until the result is registered
// reset: synchronous, active high; afterward a clearing pass chains the free list in the
//   next-link memory, one link per node, with no request taken until it ends
`default_nettype none

module sorted_list_priority_queue #(
  parameter int CAPACITY = slpq_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration: relation_mode
  input  wire logic                               cfg_we,
  input  wire logic [slpq_pkg::MODE_W-1:0]        cfg_wdata,
  // request stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [slpq_pkg::IN_DATA_W-1:0]     s_tdata,   // element_value, priority_value
  input  wire logic [slpq_pkg::CMD_W-1:0]         s_tuser,   // command
  // result stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [slpq_pkg::OUT_DATA_W-1:0]    m_tdata,   // out_element, out_priority,
                                                             // entry_count, zero pad
  output logic      [slpq_pkg::STATUS_W-1:0]      m_tuser    // status
);

  import slpq_pkg::*;

  // address width of the node store and width of a link (holds the null code)
  localparam int AW = $clog2(CAPACITY);
  localparam int IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

  // sequencer states
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,  // chain the free list after reset
    S_IDLE  = 9'b000000010,  // wait for a request
    S_ALLOC = 9'b000000100,  // take a node off the free list, start the walk at head
    S_HEAD  = 9'b000001000,  // head read for pop, top and lookup
    S_WALK  = 9'b000010000,  // one node per cycle through the shared compare unit
    S_LINK1 = 9'b000100000,  // write links of the new node
    S_LINK2 = 9'b001000000,  // patch neighbors, head and tail
    S_POP   = 9'b010000000,  // return head, unlink on pop
    S_FIN   = 9'b100000000   // hand the result to the output register
  } state_t;

  function automatic logic live(input logic [IW-1:0] idx);
    return idx < NULL_IDX;
  endfunction

  state_t          state;
  logic [AW-1:0]   clr;
  rel_t            relation_mode;

  // list state
  logic [IW-1:0]   head_index;
  logic [IW-1:0]   tail_index;
  logic [IW-1:0]   free_head;
  logic [IW-1:0]   held_count;

  // request held for the whole operation
  cmd_t            req_cmd;
  logic [ELEM_W-1:0] req_elem;
  logic [PRIO_W-1:0] req_prio;

  // walk and link registers
  logic [IW-1:0]   cur;       // node whose read data is on the memory outputs
  logic [IW-1:0]   alloc;     // node taken for a push
  logic [IW-1:0]   link_nx;   // successor of the new node
  logic [IW-1:0]   link_pv;   // predecessor of the new node

  // result being built
  status_t           res_status;
  logic [ELEM_W-1:0] res_elem;
  logic [PRIO_W-1:0] res_prio;

  // memory ports
  logic [AW-1:0]              raddr;
  logic                       dat_we;
  logic [ELEM_W+PRIO_W-1:0]   dat_rdata;
  logic                       nx_we;
  logic [AW-1:0]              nx_waddr;
  logic [IW-1:0]              nx_wdata;
  logic [IW-1:0]              nx_rdata;
  logic                       pv_we;
  logic [AW-1:0]              pv_waddr;
  logic [IW-1:0]              pv_wdata;
  logic [IW-1:0]              pv_rdata;

  logic [ELEM_W-1:0] stored_elem;
  logic [PRIO_W-1:0] stored_prio;
  cmp_res_t          cmp_res;
  logic              out_load;

  assign stored_elem = dat_rdata[ELEM_W-1:0];
  assign stored_prio = dat_rdata[ELEM_W+PRIO_W-1:ELEM_W];

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  // one read address shared by the three memories: the walk always reads a whole node
  always_comb begin
    unique case (state)
      S_ALLOC, S_HEAD: raddr = head_index[AW-1:0];
      S_WALK:          raddr = nx_rdata[AW-1:0];
      default:         raddr = free_head[AW-1:0];  // idle: prefetch next free link
    endcase
  end

  assign dat_we = (state == S_ALLOC);

  // next-link writes: free list chain, new node, predecessor patch, node return on pop
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = alloc[AW-1:0];
    nx_wdata = link_nx;
    unique case (state)
      S_CLEAR: begin
        nx_we    = 1'b1;
        nx_waddr = clr;
        nx_wdata = IW'(clr) + IW'(1);
      end
      S_LINK1: begin
        nx_we = 1'b1;
      end
      S_LINK2: begin
        nx_we    = live(link_pv);
        nx_waddr = link_pv[AW-1:0];
        nx_wdata = alloc;
      end
      S_POP: begin
        nx_we    = (req_cmd == CMD_POP);
        nx_waddr = head_index[AW-1:0];
        nx_wdata = free_head;
      end
      default: nx_we = 1'b0;
    endcase
  end

  // prev-link writes
  always_comb begin
    pv_we    = 1'b0;
    pv_waddr = alloc[AW-1:0];
    pv_wdata = link_pv;
    unique case (state)
      S_LINK1: begin
        pv_we = 1'b1;
      end
      S_LINK2: begin
        pv_we    = live(link_nx);
        pv_waddr = link_nx[AW-1:0];
        pv_wdata = alloc;
      end
      S_POP: begin
        pv_we    = (req_cmd == CMD_POP) && live(nx_rdata);
        pv_waddr = nx_rdata[AW-1:0];
        pv_wdata = NULL_IDX;
      end
      default: pv_we = 1'b0;
    endcase
  end

  // node payload: priority above element
  slpq_ram #(
    .WIDTH (ELEM_W + PRIO_W),
    .DEPTH (CAPACITY)
  ) u_node_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (alloc[AW-1:0]),
    .wdata ({req_prio, req_elem}),
    .raddr (raddr),
    .rdata (dat_rdata)
  );

  slpq_ram #(
    .WIDTH (IW),
    .DEPTH (CAPACITY)
  ) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (raddr),
    .rdata (nx_rdata)
  );

  slpq_ram #(
    .WIDTH (IW),
    .DEPTH (CAPACITY)
  ) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (raddr),
    .rdata (pv_rdata)
  );

  // shared compare unit
  slpq_cmp u_cmp (
    .mode        (relation_mode),
    .stored_prio (stored_prio),
    .fresh_prio  (req_prio),
    .stored_elem (stored_elem),
    .key_elem    (req_elem),
    .res         (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      relation_mode <= REL_LE;
      head_index    <= NULL_IDX;
      tail_index    <= NULL_IDX;
      free_head     <= '0;
      held_count    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        relation_mode <= rel_t'(cfg_wdata);
      end

      // output register: a finished result waits here until taken
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tuser  <= res_status;
        m_tdata  <= {3'b000, COUNT_W'(held_count), res_prio, res_elem};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (s_tvalid) begin
            req_cmd    <= cmd_t'(s_tuser);
            req_elem   <= s_tdata[ELEM_W-1:0];
            req_prio   <= s_tdata[ELEM_W+PRIO_W-1:ELEM_W];
            res_status <= ST_OK;
            res_elem   <= '0;
            res_prio   <= '0;
            unique case (cmd_t'(s_tuser))
              CMD_PUSH: begin
                if (live(free_head)) begin
                  alloc <= free_head;
                  state <= S_ALLOC;
                end else begin
                  res_status <= ST_FULL;
                  state      <= S_FIN;
                end
              end
              CMD_POP, CMD_TOP: begin
                if (held_count == '0 || !live(head_index)) begin
                  res_status <= ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  state <= S_HEAD;
                end
              end
              CMD_LOOKUP: begin
                // a miss unless the walk finds the element
                res_status <= ST_NOT_FOUND;
                res_prio   <= '1;
                state      <= live(head_index) ? S_HEAD : S_FIN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_ALLOC: begin
          // next link of the taken node is on the read port, prefetched while idle
          free_head <= nx_rdata;
          cur       <= head_index;
          if (live(head_index)) begin
            state <= S_WALK;
          end else begin
            link_nx <= NULL_IDX;
            link_pv <= tail_index;
            state   <= S_LINK1;
          end
        end

        S_HEAD: begin
          cur   <= head_index;
          state <= (req_cmd == CMD_LOOKUP) ? S_WALK : S_POP;
        end

        S_WALK: begin
          if (req_cmd == CMD_PUSH) begin
            if (cmp_res.keep) begin
              if (live(nx_rdata)) begin
                cur <= nx_rdata;
              end else begin
                // ran off the end: append at tail
                link_nx <= NULL_IDX;
                link_pv <= tail_index;
                state   <= S_LINK1;
              end
            end else begin
              // insert before the node that failed the test
              link_nx <= cur;
              link_pv <= pv_rdata;
              state   <= S_LINK1;
            end
          end else begin
            if (cmp_res.match) begin
              res_status <= ST_OK;
              res_prio   <= stored_prio;
              state      <= S_FIN;
            end else if (live(nx_rdata)) begin
              cur <= nx_rdata;
            end else begin
              state <= S_FIN;
            end
          end
        end

        S_LINK1: begin
          state <= S_LINK2;
        end

        S_LINK2: begin
          if (!live(link_pv)) begin
            head_index <= alloc;
          end
          if (!live(link_nx)) begin
            tail_index <= alloc;
          end
          held_count <= held_count + IW'(1);
          state      <= S_FIN;
        end

        S_POP: begin
          res_elem <= stored_elem;
          res_prio <= stored_prio;
          if (req_cmd == CMD_POP) begin
            head_index <= nx_rdata;
            if (!live(nx_rdata)) begin
              tail_index <= NULL_IDX;
            end
            free_head  <= head_index;
            held_count <= held_count - IW'(1);
          end
          state <= S_FIN;
        end

        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // list bookkeeping never exceeds the node store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= NULL_IDX)
    else $error("held count above capacity");

  // head and tail become null together
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (head_index == NULL_IDX) == (tail_index == NULL_IDX))
    else $error("head and tail disagree on empty list");

  // an empty count goes with a null head
  a_count_head: assert property (@(posedge clk) disable iff (rst)
    (held_count == '0) == (head_index == NULL_IDX))
    else $error("held count disagrees with head");

  // a result appears only from the hand-off state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FIN))
    else $error("result shown outside hand-off");
`endif

endmodule

`default_nettype wire

[sv/slpq_ram.sv]
`default_nettype none

module slpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/slpq_cmp.sv]
`default_nettype none

module slpq_cmp (
  input  wire slpq_pkg::rel_t                      mode,
  input  wire logic signed [slpq_pkg::PRIO_W-1:0]  stored_prio,
  input  wire logic signed [slpq_pkg::PRIO_W-1:0]  fresh_prio,
  input  wire logic        [slpq_pkg::ELEM_W-1:0]  stored_elem,
  input  wire logic        [slpq_pkg::ELEM_W-1:0]  key_elem,
  output slpq_pkg::cmp_res_t                       res
);

  import slpq_pkg::*;

  // signed priority order test and element match, shared by push and lookup walks
  always_comb begin
    unique case (mode)
      REL_LE: res.keep = (stored_prio <= fresh_prio);
      REL_LT: res.keep = (stored_prio <  fresh_prio);
      REL_GE: res.keep = (stored_prio >= fresh_prio);
      REL_GT: res.keep = (stored_prio >  fresh_prio);
      default: res.keep = 1'b0;
    endcase
    res.match = (stored_elem == key_elem);
  end

endmodule

`default_nettype wire

[tb/slpq_reply_checker.sv]
`default_nettype none

module slpq_reply_checker #(
  parameter int CAPACITY = slpq_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [slpq_pkg::MODE_W-1:0]     cfg_wdata,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  input  wire logic [slpq_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [slpq_pkg::CMD_W-1:0]      s_tuser,
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic [slpq_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic [slpq_pkg::STATUS_W-1:0]   m_tuser,
  output int                                   fail_count,
  output int                                   pending
);
  import slpq_pkg::*;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    status_t            status;
    logic [ELEM_W-1:0]  elem;
    logic [PRIO_W-1:0]  prio;
    logic [COUNT_W-1:0] count;
  } reply_t;

  // queue contents in list order, head first
  entry_t queue_image[$];
  reply_t awaited_replies[$];
  rel_t   relation;
  int     errors;
  int     reply_num;

  function automatic bit walks_past(logic signed [PRIO_W-1:0] stored,
                                    logic signed [PRIO_W-1:0] fresh);
    case (relation)
      REL_LE:  return stored <= fresh;
      REL_LT:  return stored < fresh;
      REL_GE:  return stored >= fresh;
      default: return stored > fresh;
    endcase
  endfunction

  function automatic reply_t predict_reply(cmd_t cmd, logic [ELEM_W-1:0] elem,
                                           logic [PRIO_W-1:0] prio);
    reply_t r;
    entry_t e;
    int     pos;
    r = '{status: ST_OK, elem: '0, prio: '0, count: '0};
    case (cmd)
      CMD_PUSH: begin
        if (queue_image.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < queue_image.size() &&
                 walks_past($signed(queue_image[pos].prio), $signed(prio)))
            pos++;
          e.elem = elem;
          e.prio = prio;
          queue_image.insert(pos, e);
        end
      end
      CMD_POP, CMD_TOP: begin
        if (queue_image.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.elem = queue_image[0].elem;
          r.prio = queue_image[0].prio;
          if (cmd == CMD_POP)
            void'(queue_image.pop_front());
        end
      end
      default: begin
        r.status = ST_NOT_FOUND;
        r.prio   = '1;
        for (int i = 0; i < queue_image.size(); i++) begin
          if (queue_image[i].elem == elem) begin
            r.status = ST_OK;
            r.prio   = queue_image[i].prio;
            break;
          end
        end
      end
    endcase
    r.count = COUNT_W'(queue_image.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("reply %0d: %0s got %h want %h", reply_num, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      queue_image.delete();
      awaited_replies.delete();
      relation = REL_LE;
    end else begin
      if (cfg_we)
        relation = rel_t'(cfg_wdata);
      if (m_tvalid && m_tready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected reply", {m_tuser, m_tdata[29:0]}, '0);
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", 32'(m_tuser), 32'(want.status));
          check_field("element", 32'(m_tdata[15:0]), 32'(want.elem));
          check_field("priority", 32'(m_tdata[31:16]), 32'(want.prio));
          check_field("count", 32'(m_tdata[36:32]), 32'(want.count));
          check_field("pad", 32'(m_tdata[39:37]), '0);
        end
        reply_num++;
      end
      if (s_tvalid && s_tready)
        awaited_replies.push_back(predict_reply(cmd_t'(s_tuser), s_tdata[15:0],
                                                s_tdata[31:16]));
    end
    fail_count <= errors;
    pending    <= awaited_replies.size();
  end

endmodule

`default_nettype wire

[tb/tb_sorted_list_priority_queue.sv]
`default_nettype none

module tb_sorted_list_priority_queue;
  import slpq_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  // far above the slowest run: every push walking the full list, long stalls
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 400;
  // worst push latency plus margin, waited out at the end
  localparam int DRAIN_CYCLES = CAPACITY + 10;
  localparam int PHASE_ITEMS  = 228;
  localparam int PHASES       = 8;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [MODE_W-1:0]     cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [CMD_W-1:0]      s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // idling knobs, percent of cycles
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // long receiver hold-off, requested once by the stimulus
  bit start_hold = 1'b0;
  bit hold_done  = 1'b0;
  int hold_left  = 0;

  // relation used in each random phase, both extremes included
  rel_t phase_mode [PHASES] = '{REL_LE, REL_GT, REL_LT, REL_GE,
                                REL_GT, REL_LE, REL_GE, REL_LT};

  always #5 clk = ~clk;

  sorted_list_priority_queue #(.CAPACITY(CAPACITY)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  slpq_reply_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: random stalls, or one long hold-off so the block backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (start_hold && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one request, with random idle cycles ahead of it; returns on the accepting edge
  task automatic offer_request(cmd_t cmd, logic [ELEM_W-1:0] elem,
                               logic [PRIO_W-1:0] prio);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {prio, elem};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // relation write, only once every reply has come back
  task automatic set_relation(rel_t mode);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random requests in bursts that lean toward filling or draining the queue
  task automatic run_random(int count);
    int   push_pct;
    int   burst_left;
    int   r;
    cmd_t cmd;
    logic [ELEM_W-1:0] elem;
    logic [PRIO_W-1:0] prio;
    push_pct   = 50;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(12, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 45;
          default: push_pct = 15;
        endcase
      end
      burst_left--;
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        cmd = CMD_PUSH;
      end else begin
        r = $urandom_range(0, 9);
        cmd = (r < 5) ? CMD_POP : (r < 7) ? CMD_TOP : CMD_LOOKUP;
      end
      // small element pool so lookups hit and duplicates occur
      if ($urandom_range(0, 1) == 0)
        elem = ELEM_W'($urandom_range(0, 15));
      else
        elem = ELEM_W'($urandom());
      // tied small priorities in 8 of 20 draws, some extremes, rest full range
      r = $urandom_range(0, 19);
      if (r < 8) begin
        prio = PRIO_W'($urandom_range(0, 6)) - PRIO_W'(3);
      end else if (r < 11) begin
        case ($urandom_range(0, 3))
          0:       prio = 16'h8000;
          1:       prio = 16'h7fff;
          2:       prio = 16'hffff;
          default: prio = 16'h0000;
        endcase
      end else begin
        prio = PRIO_W'($urandom());
      end
      offer_request(cmd, elem, prio);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed requests, ascending order with ties kept in arrival order
    set_relation(REL_LE);
    offer_request(CMD_POP, 16'h0000, 16'h0000);     // pop on empty queue
    offer_request(CMD_TOP, 16'h0000, 16'h0000);     // top on empty queue
    offer_request(CMD_LOOKUP, 16'h0000, 16'h0000);  // lookup on empty queue
    offer_request(CMD_PUSH, 16'h0000, 16'h8000);    // lowest priority
    offer_request(CMD_PUSH, 16'hffff, 16'h7fff);    // highest priority
    offer_request(CMD_PUSH, 16'h1234, 16'h0000);
    offer_request(CMD_PUSH, 16'h4321, 16'h0000);    // equal priority
    offer_request(CMD_PUSH, 16'ha5a5, 16'hffff);
    offer_request(CMD_TOP, 16'h0000, 16'h0000);
    offer_request(CMD_LOOKUP, 16'hffff, 16'h0000);  // hit at the tail
    offer_request(CMD_LOOKUP, 16'h4321, 16'h0000);  // hit in the middle
    offer_request(CMD_LOOKUP, 16'h5a5a, 16'h0000);  // miss
    // fill the store
    for (int i = 0; i < CAPACITY - 5; i++)
      offer_request(CMD_PUSH, ELEM_W'(16'h0100 + i), PRIO_W'(i * 3 - 15));
    offer_request(CMD_PUSH, 16'hbeef, 16'h0001);    // push on full queue
    offer_request(CMD_POP, 16'h0000, 16'h0000);
    offer_request(CMD_POP, 16'h0000, 16'h0000);

    // random phases: none, sender idle, receiver stall, both
    for (int p = 0; p < PHASES; p++) begin
      set_relation(phase_mode[p]);
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 73;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 73;
        end
        default: begin
          sender_idle_pct = 30;
          recv_stall_pct  = 30;
        end
      endcase
      // back-pressure: sender keeps offering while the receiver holds off
      if (p == 4)
        start_hold = 1'b1;
      run_random(PHASE_ITEMS);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // let any stray reply show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
